// File: sv/vtp_pkg.sv
// Shared constants, codes and helper functions for the test pattern pixel generator.
package vtp_pkg;

  // Default coordinate width.
  localparam int COORD_BITS_DEF = 10;

  // Width of the frame number field.
  localparam int FRAME_BITS = 10;

  // Width of an RGB565 color.
  localparam int COLOR_BITS = 16;

  // Display mode codes.
  localparam logic [2:0] MODE_WHITE   = 3'd0;
  localparam logic [2:0] MODE_REFRESH = 3'd1;
  localparam logic [2:0] MODE_RED     = 3'd2;
  localparam logic [2:0] MODE_GREEN   = 3'd3;
  localparam logic [2:0] MODE_BLUE    = 3'd4;
  localparam logic [2:0] MODE_PATTERN = 3'd5;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  // Reset values of the registers.
  localparam int RESET_WIDTH  = 480;
  localparam int RESET_HEIGHT = 480;

  // Pattern geometry.
  localparam int REFRESH_FRAMES = 600;
  localparam int SQUARE         = 24;
  localparam int CHECK_LO       = 120;
  localparam int CHECK_HI       = 360;
  localparam int NUM_BARS       = 8;
  localparam int CHECK_CELLS    = (CHECK_HI - CHECK_LO) / SQUARE;

  // RGB565 colors.
  localparam logic [15:0] C_WHITE   = 16'hFFFF;
  localparam logic [15:0] C_BLACK   = 16'h0000;
  localparam logic [15:0] C_RED     = 16'hF800;
  localparam logic [15:0] C_ORANGE  = 16'hFC00;
  localparam logic [15:0] C_GREEN   = 16'h07E0;
  localparam logic [15:0] C_CYAN    = 16'h07FF;
  localparam logic [15:0] C_BLUE    = 16'h001F;
  localparam logic [15:0] C_MAGENTA = 16'hF81F;

  // Color of each vertical bar, left to right.
  function automatic logic [15:0] bar_color(input logic [2:0] bar);
    logic [15:0] c;
    case (bar)
      3'd0:    c = C_RED;
      3'd1:    c = C_ORANGE;
      3'd2:    c = C_GREEN;
      3'd3:    c = C_CYAN;
      3'd4:    c = C_BLUE;
      3'd5:    c = C_MAGENTA;
      3'd6:    c = C_WHITE;
      default: c = C_BLACK;
    endcase
    return c;
  endfunction

  // Parity of the checkerboard cell index for an offset into the region.
  // Each threshold at a multiple of the square size flips the parity.
  function automatic logic check_parity(input logic [7:0] d);
    logic p;
    p = 1'b0;
    for (int k = 1; k < CHECK_CELLS; k++) begin
      if (d >= 8'(SQUARE * k)) begin
        p = ~p;
      end
    end
    return p;
  endfunction

endpackage

// File: sv/video_test_pattern_pixel_generator.sv
// Top level of the test pattern pixel generator: register port and color pipeline.
//
// Usage: each item on the in_ stream carries one pixel coordinate and a frame
// number; the out_ stream returns that pixel's RGB565 color, one item per input
// item, in order. The mode and frame size are set through the cfg_ register port
// (mode at 0x0, width at 0x4, height at 0x8) while no items are in flight.
//
// Throughput is one item per clock while the receiver keeps out_tready high.
// out_tvalid is driven by the output register: the pipeline has
// a classification stage and two more stages that finish the three-bit bar index,
// one restoring division step each against the frame width, with the output
// register as the last stage.
//
// Reset clears all stage valid bits and loads the default registers (white mode,
// 480 by 480). When the receiver holds out_tready low, the result stays in the
// output register and earlier stages keep filling; in_tready drops once all
// three stages hold an item, and nothing is dropped or repeated.
module video_test_pattern_pixel_generator #(
  parameter int COORD_BITS = vtp_pkg::COORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input item: pixel_x, pixel_y, frame_number, from the lowest bit up, zero padded.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [((2*COORD_BITS+vtp_pkg::FRAME_BITS+7)/8)*8-1:0] in_tdata,
  // Result item: pixel_color.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,
  // Register port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int CB = COORD_BITS;
  localparam int FB = vtp_pkg::FRAME_BITS;

  logic [2:0]    mode_r;
  logic [CB-1:0] width_r, height_r;
  logic          cfg_wr;
  logic [1:0]    cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= vtp_pkg::MODE_WHITE;
      width_r  <= CB'(vtp_pkg::RESET_WIDTH);
      height_r <= CB'(vtp_pkg::RESET_HEIGHT);
    end else if (cfg_wr) begin
      case (cfg_idx)
        vtp_pkg::REG_MODE:   mode_r   <= cfg_pwdata[2:0];
        vtp_pkg::REG_WIDTH:  width_r  <= cfg_pwdata[CB-1:0];
        vtp_pkg::REG_HEIGHT: height_r <= cfg_pwdata[CB-1:0];
        default: ;
      endcase
    end
  end

  // Register readback.
  always_comb begin
    case (cfg_idx)
      vtp_pkg::REG_MODE:   cfg_prdata = {29'd0, mode_r};
      vtp_pkg::REG_WIDTH:  cfg_prdata = 32'(width_r);
      vtp_pkg::REG_HEIGHT: cfg_prdata = 32'(height_r);
      default:             cfg_prdata = 32'd0;
    endcase
  end

  vtp_color_pipe #(
    .COORD_BITS (COORD_BITS)
  ) u_pipe (
    .clk          (clk),
    .rst_n        (rst_n),
    .mode         (mode_r),
    .width        (width_r),
    .height       (height_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .pixel_x      (in_tdata[CB-1:0]),
    .pixel_y      (in_tdata[2*CB-1:CB]),
    .frame_number (in_tdata[2*CB+FB-1:2*CB]),
    .out_valid    (out_tvalid),
    .out_ready    (out_tready),
    .pixel_color  (out_tdata)
  );

endmodule

// File: sv/vtp_color_pipe.sv
// Three-stage color pipeline: classification, then a bar index found by restoring division.
module vtp_color_pipe #(
  parameter int COORD_BITS = vtp_pkg::COORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [2:0]                       mode,
  input  logic [COORD_BITS-1:0]            width,
  input  logic [COORD_BITS-1:0]            height,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [COORD_BITS-1:0]            pixel_x,
  input  logic [COORD_BITS-1:0]            pixel_y,
  input  logic [vtp_pkg::FRAME_BITS-1:0]   frame_number,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [vtp_pkg::COLOR_BITS-1:0]   pixel_color
);

  localparam int CB = COORD_BITS;
  localparam int NB = CB + 3;
  localparam logic [CB:0]   SQ_EXT  = (CB + 1)'(vtp_pkg::SQUARE);
  localparam logic [CB-1:0] SQ_C    = CB'(vtp_pkg::SQUARE);
  localparam logic [CB-1:0] LO_C    = CB'(vtp_pkg::CHECK_LO);
  localparam logic [CB-1:0] HI_C    = CB'(vtp_pkg::CHECK_HI);
  localparam logic [CB-1:0] ONE_C   = CB'(1);
  localparam logic [9:0]    REFR_C  = 10'(vtp_pkg::REFRESH_FRAMES);

  // Stage valids and handshake chain.
  logic v1_r, v2_r, v3_r;
  logic s1_ready, s2_ready, s3_ready;

  assign s3_ready = !v3_r || out_ready;
  assign s2_ready = !v2_r || s3_ready;
  assign s1_ready = !v1_r || s2_ready;
  assign in_ready = s1_ready;

  // Stage payloads.
  logic [15:0]   color1_r, color2_r, color3_r;
  logic          bar1_r, bar2_r;
  logic [NB-1:0] rem1_r, rem2_r;
  logic [2:0]    q1_r, q2_r;

  logic [15:0]   color1_nxt;
  logic          bar1_nxt;
  logic [NB-1:0] rem1_nxt, rem2_nxt;
  logic [2:0]    q1_nxt, q2_nxt;
  logic [15:0]   color3_nxt;

  // Stage one: frame test, mode, corner, checker and border layers, first quotient bit.
  always_comb begin
    logic in_frame, left, right, top, bottom, in_check, border;
    logic [CB-1:0] dx, dy;
    logic [NB-1:0] n, d4;
    in_frame = (pixel_x < width) && (pixel_y < height);
    left     = pixel_x < SQ_C;
    top      = pixel_y < SQ_C;
    right    = ({1'b0, pixel_x} + SQ_EXT) >= {1'b0, width};
    bottom   = ({1'b0, pixel_y} + SQ_EXT) >= {1'b0, height};
    in_check = (pixel_x >= LO_C) && (pixel_x < HI_C) &&
               (pixel_y >= LO_C) && (pixel_y < HI_C);
    border   = (pixel_x == '0) || (pixel_y == '0) ||
               (pixel_x == width - ONE_C) || (pixel_y == height - ONE_C);
    dx       = pixel_x - LO_C;
    dy       = pixel_y - LO_C;
    bar1_nxt   = 1'b0;
    color1_nxt = vtp_pkg::C_BLACK;
    if (in_frame) begin
      case (mode)
        vtp_pkg::MODE_WHITE: color1_nxt = vtp_pkg::C_WHITE;
        vtp_pkg::MODE_REFRESH: begin
          if (frame_number < REFR_C && !frame_number[0]) begin
            color1_nxt = vtp_pkg::C_BLACK;
          end else begin
            color1_nxt = vtp_pkg::C_WHITE;
          end
        end
        vtp_pkg::MODE_RED:   color1_nxt = vtp_pkg::C_RED;
        vtp_pkg::MODE_GREEN: color1_nxt = vtp_pkg::C_GREEN;
        vtp_pkg::MODE_BLUE:  color1_nxt = vtp_pkg::C_BLUE;
        vtp_pkg::MODE_PATTERN: begin
          if (right && bottom) begin
            color1_nxt = vtp_pkg::C_WHITE;
          end else if (left && bottom) begin
            color1_nxt = vtp_pkg::C_BLUE;
          end else if (right && top) begin
            color1_nxt = vtp_pkg::C_GREEN;
          end else if (left && top) begin
            color1_nxt = vtp_pkg::C_RED;
          end else if (in_check) begin
            color1_nxt = (vtp_pkg::check_parity(dx[7:0]) ^ vtp_pkg::check_parity(dy[7:0]))
                         ? vtp_pkg::C_WHITE : vtp_pkg::C_BLACK;
          end else if (border) begin
            color1_nxt = vtp_pkg::C_WHITE;
          end else begin
            bar1_nxt = 1'b1;
          end
        end
        default: color1_nxt = vtp_pkg::C_BLACK;
      endcase
    end
    // Bar index is (8x)/width; take the top quotient bit here.
    n  = {pixel_x, 3'b000};
    d4 = {1'b0, width, 2'b00};
    if (n >= d4) begin
      rem1_nxt = n - d4;
      q1_nxt   = 3'b100;
    end else begin
      rem1_nxt = n;
      q1_nxt   = 3'b000;
    end
  end

  // Stage two: middle quotient bit.
  always_comb begin
    logic [NB-1:0] d2;
    d2 = {2'b00, width, 1'b0};
    if (rem1_r >= d2) begin
      rem2_nxt = rem1_r - d2;
      q2_nxt   = q1_r | 3'b010;
    end else begin
      rem2_nxt = rem1_r;
      q2_nxt   = q1_r;
    end
  end

  // Stage three: last quotient bit and the final color pick.
  always_comb begin
    logic [2:0] q;
    q = q2_r | ((rem2_r >= {3'b000, width}) ? 3'b001 : 3'b000);
    color3_nxt = bar2_r ? vtp_pkg::bar_color(q) : color2_r;
  end

  // Valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (s1_ready) v1_r <= in_valid;
      if (s2_ready) v2_r <= v1_r;
      if (s3_ready) v3_r <= v2_r;
    end
  end

  // Payload registers advance with their stage.
  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      color1_r <= color1_nxt;
      bar1_r   <= bar1_nxt;
      rem1_r   <= rem1_nxt;
      q1_r     <= q1_nxt;
    end
    if (s2_ready && v1_r) begin
      color2_r <= color1_r;
      bar2_r   <= bar1_r;
      rem2_r   <= rem2_nxt;
      q2_r     <= q2_nxt;
    end
    if (s3_ready && v2_r) begin
      color3_r <= color3_nxt;
    end
  end

  assign out_valid   = v3_r;
  assign pixel_color = color3_r;

  // A full pipeline with a stalled receiver takes no item.
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && !out_ready) |-> !in_ready)
    else $error("item accepted into a full stalled pipeline");

  // An accepted item shows up in stage one.
  a_accept_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> v1_r)
    else $error("accepted item lost at stage one");

  // An item moving out of stage two lands in the output stage.
  a_mid_move: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && s3_ready) |=> v3_r)
    else $error("item lost between stage two and output");

  // A bar pixel lies inside the frame, so its partial remainder stays below twice the width.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && bar2_r) |-> (rem2_r < {2'b00, width, 1'b0}))
    else $error("bar division remainder out of range");

endmodule

// File: tb/video_test_pattern_pixel_generator_tb.sv
// Testbench for the test pattern pixel generator: stream stimulus, color prediction and checks.
module video_test_pattern_pixel_generator_tb;
  import vtp_pkg::*;

  // A register index that decodes to no register; writes to it must be ignored.
  localparam logic [1:0] REG_SPARE = 2'd3;
  // Cycles without any accepted item before the run is declared hung.
  localparam int STALL_LIMIT = 2000;
  // Length of the long receiver hold-off.
  localparam int HOLD_CYCLES = 80;
  localparam int PHASES = 11;
  localparam int PHASE_ITEMS = 50;

  // Keeps its own copy of the registers and the colors still owed by the block.
  class color_scoreboard;
    logic [2:0] mode;
    logic [9:0] width;
    logic [9:0] height;
    logic [15:0] pending[$];
    int errors;

    function new();
      mode = MODE_WHITE;
      width = 10'(RESET_WIDTH);
      height = 10'(RESET_HEIGHT);
      errors = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [31:0] value);
      case (idx)
        REG_MODE:   mode = value[2:0];
        REG_WIDTH:  width = value[9:0];
        REG_HEIGHT: height = value[9:0];
        default:    ;
      endcase
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // Work out the color of one accepted pixel and queue it.
    function void note_pixel(logic [9:0] x, logic [9:0] y, logic [9:0] frame);
      int unsigned xi, yi, w, h, bar;
      logic [15:0] color;
      xi = x;
      yi = y;
      w = width;
      h = height;
      if (xi >= w || yi >= h) begin
        color = C_BLACK;
      end else begin
        case (mode)
          MODE_WHITE:   color = C_WHITE;
          MODE_REFRESH: color = (frame < REFRESH_FRAMES && !frame[0]) ? C_BLACK : C_WHITE;
          MODE_RED:     color = C_RED;
          MODE_GREEN:   color = C_GREEN;
          MODE_BLUE:    color = C_BLUE;
          MODE_PATTERN: begin
            // Corner squares first, bottom-right winning any overlap.
            if (xi + SQUARE >= w && yi + SQUARE >= h) begin
              color = C_WHITE;
            end else if (xi < SQUARE && yi + SQUARE >= h) begin
              color = C_BLUE;
            end else if (xi + SQUARE >= w && yi < SQUARE) begin
              color = C_GREEN;
            end else if (xi < SQUARE && yi < SQUARE) begin
              color = C_RED;
            end else if (xi >= CHECK_LO && xi < CHECK_HI && yi >= CHECK_LO && yi < CHECK_HI) begin
              color = ((((xi - CHECK_LO) / SQUARE) ^ ((yi - CHECK_LO) / SQUARE)) & 1)
                      ? C_WHITE : C_BLACK;
            end else if (xi == 0 || yi == 0 || xi == w - 1 || yi == h - 1) begin
              color = C_WHITE;
            end else begin
              bar = ((xi * NUM_BARS) / w) & 7;
              case (bar)
                0:       color = C_RED;
                1:       color = C_ORANGE;
                2:       color = C_GREEN;
                3:       color = C_CYAN;
                4:       color = C_BLUE;
                5:       color = C_MAGENTA;
                6:       color = C_WHITE;
                default: color = C_BLACK;
              endcase
            end
          end
          default: color = C_BLACK;
        endcase
      end
      pending.push_back(color);
    endfunction

    // Compare one accepted result with the oldest queued color.
    task check_color(logic [15:0] got);
      logic [15:0] want;
      if (pending.size() == 0) begin
        report($sformatf("pixel color %h arrived with none queued", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        report($sformatf("pixel color %h, predicted %h", got, want));
      end
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  // Fields from the lowest bit up: pixel_x, pixel_y, frame_number, two zero bits.
  logic [31:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  // Fields: pixel_color.
  logic [15:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  bit src_idle;
  bit sink_idle;
  bit hold_wanted;
  int stall_count;
  color_scoreboard sb;

  video_test_pattern_pixel_generator i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Handshakes are observed at the falling edge, where every signal is settled
  // for the rising edge that follows.
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        sb.note_pixel(in_tdata[9:0], in_tdata[19:10], in_tdata[29:20]);
      end
      if (out_tvalid && out_tready) begin
        sb.check_color(out_tdata);
      end
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= !(sink_idle && $urandom_range(0, 99) < 17);
      end
    end
  end

  // Offer one pixel and return at the rising edge that accepts it.
  task automatic send_pixel(input int unsigned x, input int unsigned y, input int unsigned frame);
    bit taken;
    while (src_idle && $urandom_range(0, 99) < 17) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, 10'(frame), 10'(y), 10'(x)};
    do begin
      @(negedge clk);
      taken = in_tready;
      @(posedge clk);
    end while (!taken);
  endtask

  // Stop offering and wait until every queued color has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Write one register, then read it back in a second transfer.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    logic [31:0] want;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    sb.set_register(idx, value);
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    case (idx)
      REG_MODE:   want = 32'(sb.mode);
      REG_WIDTH:  want = 32'(sb.width);
      REG_HEIGHT: want = 32'(sb.height);
      default:    want = cfg_prdata;
    endcase
    if (cfg_prdata !== want) begin
      sb.report($sformatf("register %0d reads %h, written %h", idx, cfg_prdata, want));
    end
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [2:0] mode, input int unsigned w, input int unsigned h);
    wait_drained();
    write_reg(REG_MODE, 32'(mode));
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
  endtask

  // Mostly inside the frame, often near its edges, sometimes anywhere.
  function automatic int unsigned pick_coord(input int unsigned limit);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return $urandom_range(0, limit - 1);
    if (roll < 75) return $urandom_range(0, 30);
    if (roll < 85) return limit - 1 - $urandom_range(0, 30);
    return $urandom_range(0, 1023);
  endfunction

  initial begin
    logic [2:0] mode;
    int unsigned w, h, frame;
    sb = new();
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    hold_wanted = 1'b0;
    stall_count = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset registers: solid white in a 480 by 480 frame, and pixels just outside it.
    send_pixel(0, 0, 0);
    send_pixel(479, 479, 1023);
    send_pixel(480, 10, 5);
    send_pixel(10, 480, 5);
    send_pixel(1023, 1023, 1023);

    // A write to the spare address changes nothing; then pixel refresh around frame 600.
    wait_drained();
    write_reg(REG_SPARE, 32'(MODE_RED));
    write_reg(REG_MODE, 32'(MODE_REFRESH));
    send_pixel(5, 5, 0);
    send_pixel(5, 5, 1);
    send_pixel(5, 5, 599);
    send_pixel(5, 5, 600);
    send_pixel(6, 6, 598);
    send_pixel(5, 5, 1023);

    // Solid colors and the two unused modes.
    set_frame(MODE_RED, 480, 480);
    send_pixel(100, 200, 0);
    set_frame(MODE_GREEN, 480, 480);
    send_pixel(200, 100, 0);
    set_frame(MODE_BLUE, 480, 480);
    send_pixel(479, 0, 0);
    set_frame(3'd6, 480, 480);
    send_pixel(50, 50, 1);
    set_frame(3'd7, 480, 480);
    send_pixel(60, 60, 1);

    // Test pattern: the four corners, checkerboard, border and one bar.
    set_frame(MODE_PATTERN, 480, 480);
    send_pixel(0, 0, 0);
    send_pixel(479, 0, 0);
    send_pixel(0, 479, 0);
    send_pixel(479, 479, 0);
    send_pixel(120, 120, 0);
    send_pixel(144, 120, 0);
    send_pixel(240, 0, 0);
    send_pixel(300, 60, 0);

    // Smallest frame, where the four corner squares meet and cover the whole frame.
    set_frame(MODE_PATTERN, 48, 48);
    send_pixel(24, 24, 0);
    send_pixel(10, 30, 0);

    // Random phases, each with its own setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mode = MODE_PATTERN; w = 1023; h = 1023; end
        1: begin mode = MODE_PATTERN; w = 48; h = 48; end
        2: begin mode = MODE_REFRESH; w = 48; h = 1023; end
        default: begin
          mode = ($urandom_range(0, 3) != 0) ? MODE_PATTERN : 3'($urandom_range(0, 7));
          w = $urandom_range(48, 1023);
          h = $urandom_range(48, 1023);
        end
      endcase
      set_frame(mode, w, h);
      // One phase runs without any idling, another holds the receiver off.
      src_idle = (p != 4 && p != 6);
      sink_idle = (p != 4);
      if (p == 6) hold_wanted = 1'b1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (mode == MODE_REFRESH && $urandom_range(0, 9) < 3) begin
          frame = $urandom_range(590, 610);
        end else begin
          frame = $urandom_range(0, 1023);
        end
        send_pixel(pick_coord(w), pick_coord(h), frame);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/vtp_pkg.sv
sv/vtp_color_pipe.sv
sv/video_test_pattern_pixel_generator.sv
tb/video_test_pattern_pixel_generator_tb.sv
